### design/vbd_pkg.sv
// ----------------------------------------------------------------------------
// vbd_pkg
// Shared types and constants of the volume block downsampler.
// ----------------------------------------------------------------------------
`default_nettype none
package vbd_pkg;

  localparam int MAX_OUT_PIXELS_DEF = 4096;
  localparam int MAX_FACTOR_DEF     = 8;
  localparam int FRAC_BITS_DEF      = 8;

  localparam int FACT_W  = 5;
  localparam int OSXY_W  = 7;
  localparam int OSZ_W   = 11;
  localparam int IDX_W   = 16;
  localparam int SUM_W   = 24;
  localparam int CNT_W   = 10;
  localparam int VAL_W   = 16;
  localparam int RES_W   = 24;
  localparam int COL_W   = 6;
  localparam int SLICE_W = 10;
  localparam int CIDX_W  = 3;
  localparam int CDAT_W  = 11;

  localparam logic [OSXY_W-1:0] OSXY_MAX = 7'd64;
  localparam logic [OSZ_W-1:0]  OSZ_MAX  = 11'd1024;

  typedef enum logic [CIDX_W-1:0] {
    REG_MODE   = 3'd0,
    REG_FACT_X = 3'd1,
    REG_FACT_Y = 3'd2,
    REG_FACT_Z = 3'd3,
    REG_SIZE_X = 3'd4,
    REG_SIZE_Y = 3'd5,
    REG_SIZE_Z = 3'd6,
    REG_NONE   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic              mode_subsample;
    logic [FACT_W-1:0] fx;
    logic [FACT_W-1:0] fy;
    logic [FACT_W-1:0] fz;
    logic [OSXY_W-1:0] osx;
    logic [OSXY_W-1:0] osy;
    logic [OSZ_W-1:0]  osz;
  } cfg_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        idx;
    logic                    first;
    logic                    centre;
    logic                    last;
    logic                    done;
    logic [COL_W-1:0]        lx;
    logic [COL_W-1:0]        ly;
    logic [SLICE_W-1:0]      lz;
  } item_t;

endpackage
`default_nettype wire

### design/vbd_ram.sv
// ----------------------------------------------------------------------------
// vbd_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module vbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### design/vbd_front.sv
// ----------------------------------------------------------------------------
// vbd_front
// Tracks the high-resolution position and tags each voxel with its block.
// ----------------------------------------------------------------------------
`default_nettype none
module vbd_front #(
  parameter int MAX_OUT_PIXELS = vbd_pkg::MAX_OUT_PIXELS_DEF,
  localparam int IW = (MAX_OUT_PIXELS > 1) ? $clog2(MAX_OUT_PIXELS) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire vbd_pkg::cfg_t                 cfg,
  input  wire logic                          restart,
  input  wire logic                          accept,
  input  wire logic signed [vbd_pkg::VAL_W-1:0] voxel_value,
  output vbd_pkg::item_t                     item
);

  logic [vbd_pkg::FACT_W-1:0]  ox, oy, oz;
  logic [vbd_pkg::COL_W-1:0]   lx, ly;
  logic [vbd_pkg::SLICE_W-1:0] lz;
  logic [IW-1:0]               idx, rowbase;
  logic last_ox, last_oy, last_oz, end_lx, end_ly, end_lz;
  logic [IW-1:0] idx_inc;

  assign last_ox = (ox == cfg.fx - 1'b1);
  assign last_oy = (oy == cfg.fy - 1'b1);
  assign last_oz = (oz == cfg.fz - 1'b1);
  assign end_lx  = ({1'b0, lx} == cfg.osx - 1'b1);
  assign end_ly  = ({1'b0, ly} == cfg.osy - 1'b1);
  assign end_lz  = ({1'b0, lz} == cfg.osz - 1'b1);
  assign idx_inc = (idx == IW'(MAX_OUT_PIXELS - 1)) ? '0 : idx + 1'b1;

  always_comb begin
    item.value  = voxel_value;
    item.idx    = vbd_pkg::IDX_W'(idx);
    item.first  = (ox == '0) && (oy == '0) && (oz == '0);
    item.centre = (ox == (cfg.fx >> 1)) && (oy == (cfg.fy >> 1)) && (oz == (cfg.fz >> 1));
    item.last   = last_ox && last_oy && last_oz;
    item.done   = item.last && end_lx && end_ly && end_lz;
    item.lx     = lx;
    item.ly     = ly;
    item.lz     = lz;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      ox <= '0; oy <= '0; oz <= '0;
      lx <= '0; ly <= '0; lz <= '0;
      idx <= '0; rowbase <= '0;
    end else if (accept) begin
      if (!last_ox) begin
        ox <= ox + 1'b1;
      end else begin
        ox <= '0;
        if (!end_lx) begin
          lx  <= lx + 1'b1;
          idx <= idx_inc;
        end else begin
          lx <= '0;
          if (!last_oy) begin
            oy  <= oy + 1'b1;
            idx <= rowbase;
          end else begin
            oy <= '0;
            if (!end_ly) begin
              ly      <= ly + 1'b1;
              idx     <= idx_inc;
              rowbase <= idx_inc;
            end else begin
              ly      <= '0;
              idx     <= '0;
              rowbase <= '0;
              if (!last_oz) begin
                oz <= oz + 1'b1;
              end else begin
                oz <= '0;
                lz <= end_lz ? '0 : lz + 1'b1;
              end
            end
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

### design/vbd_queue.sv
// ----------------------------------------------------------------------------
// vbd_queue
// Short queue of tagged voxels between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none
module vbd_queue #(
  parameter int DEPTH = 4,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr,
  input  wire vbd_pkg::item_t wr_item,
  output logic                full,
  input  wire logic           rd,
  output vbd_pkg::item_t      rd_item,
  output logic                empty
);

  vbd_pkg::item_t slots [DEPTH];
  logic [PW-1:0]  wptr, rptr;
  logic [PW:0]    count;

  assign full    = (count == (PW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign rd_item = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wr_item;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (PW+1)'(wr) - (PW+1)'(rd);
    end
  end

endmodule
`default_nettype wire

### design/vbd_back.sv
// ----------------------------------------------------------------------------
// vbd_back
// Read-modify-write of the column store, serial divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module vbd_back #(
  parameter int MAX_OUT_PIXELS = vbd_pkg::MAX_OUT_PIXELS_DEF,
  parameter int FRAC_BITS      = vbd_pkg::FRAC_BITS_DEF,
  localparam int IW = (MAX_OUT_PIXELS > 1) ? $clog2(MAX_OUT_PIXELS) : 1,
  localparam int NW = vbd_pkg::SUM_W + FRAC_BITS,
  localparam int DW = $clog2(NW + 1),
  localparam int EW = vbd_pkg::SUM_W + vbd_pkg::CNT_W
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             mode_subsample,
  input  wire logic                             q_empty,
  input  wire vbd_pkg::item_t                   q_item,
  output logic                                  q_pop,
  output logic                                  empty,
  input  wire logic                             pop,
  output logic signed [vbd_pkg::RES_W-1:0]      result_q8,
  output logic        [vbd_pkg::COL_W-1:0]      col_out,
  output logic        [vbd_pkg::COL_W-1:0]      row_out,
  output logic        [vbd_pkg::SLICE_W-1:0]    slice_out,
  output logic                                  volume_done
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MOD  = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t         state, state_next;
  vbd_pkg::item_t cur;
  logic [EW-1:0]  rdata, wdata;
  logic           we;
  logic [vbd_pkg::SUM_W-1:0] old_sum, new_sum;
  logic [vbd_pkg::CNT_W-1:0] old_cnt, new_cnt, divisor;
  logic [NW-1:0]             quo;
  logic [vbd_pkg::CNT_W:0]   rem, rem_sh;
  logic [DW-1:0]             div_cnt;
  logic signed [vbd_pkg::RES_W-1:0] res;
  logic signed [47:0]        scaled;
  logic                      out_valid, out_free;

  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;

  assign old_sum = cur.first ? '0 : rdata[EW-1:vbd_pkg::CNT_W];
  assign old_cnt = cur.first ? '0 : rdata[vbd_pkg::CNT_W-1:0];

  always_comb begin
    we      = 1'b0;
    new_sum = rdata[EW-1:vbd_pkg::CNT_W];
    new_cnt = rdata[vbd_pkg::CNT_W-1:0];
    if (state == S_MOD) begin
      if (mode_subsample) begin
        we = cur.centre;
        if (cur.centre) begin
          new_sum = vbd_pkg::SUM_W'($unsigned(cur.value));
        end
      end else begin
        we      = 1'b1;
        new_sum = old_sum;
        new_cnt = old_cnt;
        if (cur.value > 0) begin
          new_sum = old_sum + vbd_pkg::SUM_W'(cur.value);
          new_cnt = old_cnt + 1'b1;
        end
      end
    end
    wdata = {new_sum, new_cnt};
  end

  assign scaled = 48'(signed'(new_sum[vbd_pkg::VAL_W-1:0])) <<< FRAC_BITS;
  assign rem_sh = {rem[vbd_pkg::CNT_W-1:0], quo[NW-1]};

  vbd_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_OUT_PIXELS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(cur.idx[IW-1:0]),
    .wdata(wdata),
    .raddr(q_item.idx[IW-1:0]),
    .rdata(rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (!q_empty) state_next = S_MOD;
      S_MOD: begin
        if (!cur.last) begin
          state_next = S_IDLE;
        end else if (!mode_subsample && new_cnt != '0) begin
          state_next = S_DIV;
        end else begin
          state_next = S_OUT;
        end
      end
      S_DIV:   if (div_cnt == '0) state_next = S_OUT;
      S_OUT:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
    if (q_pop) begin
      cur <= q_item;
    end
    case (state)
      S_MOD: begin
        divisor <= new_cnt;
        quo     <= NW'(new_sum) << FRAC_BITS;
        rem     <= '0;
        div_cnt <= DW'(NW - 1);
        if (mode_subsample) begin
          if (scaled > 48'sd8388607) begin
            res <= 24'sh7FFFFF;
          end else if (scaled < -48'sd8388608) begin
            res <= -24'sh800000;
          end else begin
            res <= scaled[vbd_pkg::RES_W-1:0];
          end
        end else begin
          res <= '0;
        end
      end
      S_DIV: begin
        div_cnt <= div_cnt - 1'b1;
        if (rem_sh >= {1'b0, divisor}) begin
          rem <= rem_sh - {1'b0, divisor};
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[NW-2:0], 1'b0};
        end
        if (div_cnt == '0) begin
          if (quo[NW-2:0] > (NW-1)'(24'h3FFFFF) || quo[NW-2:0] > (NW-1)'(24'h7FFFFF) >> 1
              && rem_sh >= {1'b0, divisor} && quo[NW-2:0] == (NW-1)'(24'h3FFFFF)) begin
            res <= 24'sh7FFFFF;
          end else begin
            res <= signed'(vbd_pkg::RES_W'({quo[NW-2:0],
                                            rem_sh >= {1'b0, divisor}}));
          end
        end
      end
      default: ;
    endcase
    if (state == S_OUT && out_free) begin
      result_q8   <= res;
      col_out     <= cur.lx;
      row_out     <= cur.ly;
      slice_out   <= cur.lz;
      volume_done <= cur.done;
    end
  end

endmodule
`default_nettype wire

### design/volume_block_downsampler_unit.sv
// ----------------------------------------------------------------------------
// volume_block_downsampler_unit
// Reduces a raster-order voxel stream to block averages or centroid samples.
// ----------------------------------------------------------------------------
// Usage: voxels enter through push/full in raster order, x fastest. Each
// accepted item is tagged with its block and column, then placed in a
// four-entry queue. The back part takes one item at a time through a
// read-modify-write of the column store, a registered read followed by the
// write. On the last voxel of a block, averaging mode adds a bit-serial
// division and an output step; subsample mode or an empty block adds the
// output step only. Results wait in an output register shown through
// empty/pop; while the receiver stalls, the queue absorbs up to four items
// before full rises. Configuration is written over cfg_valid/cfg_ready
// (always ready) with cfg_index and cfg_data; any write within the register
// list restarts the volume. Reset restores default registers, empties the
// queue and output register and restarts the volume; the column store needs
// no clearing.
// ----------------------------------------------------------------------------
`default_nettype none
module volume_block_downsampler_unit #(
  parameter int MAX_OUT_PIXELS = vbd_pkg::MAX_OUT_PIXELS_DEF,
  parameter int MAX_FACTOR     = vbd_pkg::MAX_FACTOR_DEF,
  parameter int FRAC_BITS      = vbd_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic signed [vbd_pkg::VAL_W-1:0]  voxel_value,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic signed [vbd_pkg::RES_W-1:0]       result_q8,
  output logic        [vbd_pkg::COL_W-1:0]       col_out,
  output logic        [vbd_pkg::COL_W-1:0]       row_out,
  output logic        [vbd_pkg::SLICE_W-1:0]     slice_out,
  output logic                                   volume_done,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [vbd_pkg::CIDX_W-1:0]        cfg_index,
  input  wire logic [vbd_pkg::CDAT_W-1:0]        cfg_data
);

  logic       mode_r;
  logic [3:0] fx_r, fy_r, fz_r;
  logic [vbd_pkg::OSXY_W-1:0] osx_r, osy_r;
  logic [vbd_pkg::OSZ_W-1:0]  osz_r;
  vbd_pkg::cfg_t  cfg;
  vbd_pkg::item_t f_item, q_item;
  logic cfg_wr, restart, accept, q_empty, q_pop;

  function automatic logic [vbd_pkg::FACT_W-1:0] clamp_f(input logic [3:0] v);
    logic [vbd_pkg::FACT_W-1:0] e;
    e = vbd_pkg::FACT_W'(v);
    if (e == '0) return vbd_pkg::FACT_W'(1);
    if (e > vbd_pkg::FACT_W'(MAX_FACTOR)) return vbd_pkg::FACT_W'(MAX_FACTOR);
    return e;
  endfunction

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign restart   = cfg_wr && (cfg_index != vbd_pkg::REG_NONE);
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_r <= 1'b0;
      fx_r   <= 4'd2;
      fy_r   <= 4'd2;
      fz_r   <= 4'd2;
      osx_r  <= 7'd64;
      osy_r  <= 7'd64;
      osz_r  <= 11'd64;
    end else if (cfg_wr) begin
      case (cfg_index)
        vbd_pkg::REG_MODE:   mode_r <= cfg_data[0];
        vbd_pkg::REG_FACT_X: fx_r   <= cfg_data[3:0];
        vbd_pkg::REG_FACT_Y: fy_r   <= cfg_data[3:0];
        vbd_pkg::REG_FACT_Z: fz_r   <= cfg_data[3:0];
        vbd_pkg::REG_SIZE_X: osx_r  <= cfg_data[6:0];
        vbd_pkg::REG_SIZE_Y: osy_r  <= cfg_data[6:0];
        vbd_pkg::REG_SIZE_Z: osz_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.mode_subsample = mode_r;
    cfg.fx  = clamp_f(fx_r);
    cfg.fy  = clamp_f(fy_r);
    cfg.fz  = clamp_f(fz_r);
    cfg.osx = (osx_r == '0) ? 7'd1 : (osx_r > vbd_pkg::OSXY_MAX) ? vbd_pkg::OSXY_MAX : osx_r;
    cfg.osy = (osy_r == '0) ? 7'd1 : (osy_r > vbd_pkg::OSXY_MAX) ? vbd_pkg::OSXY_MAX : osy_r;
    cfg.osz = (osz_r == '0) ? 11'd1 : (osz_r > vbd_pkg::OSZ_MAX) ? vbd_pkg::OSZ_MAX : osz_r;
  end

  vbd_front #(.MAX_OUT_PIXELS(MAX_OUT_PIXELS)) u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .restart(restart), .accept(accept),
    .voxel_value(voxel_value), .item(f_item)
  );

  vbd_queue #(.DEPTH(4)) u_queue (
    .clk(clk), .rst(rst), .wr(accept), .wr_item(f_item), .full(full),
    .rd(q_pop), .rd_item(q_item), .empty(q_empty)
  );

  vbd_back #(.MAX_OUT_PIXELS(MAX_OUT_PIXELS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .mode_subsample(cfg.mode_subsample),
    .q_empty(q_empty), .q_item(q_item), .q_pop(q_pop),
    .empty(empty), .pop(pop), .result_q8(result_q8), .col_out(col_out),
    .row_out(row_out), .slice_out(slice_out), .volume_done(volume_done)
  );

endmodule
`default_nettype wire

### design/vbd_checker.sv
// ----------------------------------------------------------------------------
// vbd_checker
// Port-level checks of the downsampler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module vbd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [23:0] result_q8,
  input wire logic [5:0]  col_out,
  input wire logic [5:0]  row_out,
  input wire logic [9:0]  slice_out,
  input wire logic        volume_done
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("Result pending after reset.");

  a_reset_not_full: assert property (@(posedge clk) rst |=> !full)
    else $error("Input blocked after reset.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result_q8) && $stable(col_out)
      && $stable(row_out) && $stable(slice_out) && $stable(volume_done)))
    else $error("Waiting result changed.");

endmodule

bind volume_block_downsampler_unit vbd_checker u_vbd_checker (
  .clk(clk), .rst(rst), .full(full), .empty(empty), .pop(pop),
  .result_q8(result_q8), .col_out(col_out), .row_out(row_out),
  .slice_out(slice_out), .volume_done(volume_done)
);
`default_nettype wire

### tb/volume_block_downsampler_unit_tb.sv
// ----------------------------------------------------------------------------
// volume_block_downsampler_unit_tb
// Streams voxel volumes through the downsampler under a range of block
// factors and volume sizes, in both averaging and centroid modes, and checks
// every block result and its coordinates against a built-in prediction of
// the column store arithmetic.
// ----------------------------------------------------------------------------
module volume_block_downsampler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vbd_pkg::*;

  localparam int COLUMNS    = 4096;
  localparam int SETTLE_CYC = 250;

  typedef struct {
    logic signed [RES_W-1:0] value;
    logic [COL_W-1:0]        col;
    logic [COL_W-1:0]        row;
    logic [SLICE_W-1:0]      slice;
    logic                    done;
  } block_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       push = 1'b0;
  logic                       full;
  logic signed [VAL_W-1:0]    voxel_value = '0;
  logic                       empty;
  logic                       pop = 1'b0;
  logic signed [RES_W-1:0]    result_q8;
  logic [COL_W-1:0]           col_out;
  logic [COL_W-1:0]           row_out;
  logic [SLICE_W-1:0]         slice_out;
  logic                       volume_done;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CIDX_W-1:0]          cfg_index = '0;
  logic [CDAT_W-1:0]          cfg_data = '0;

  // Predicted register file and column store.
  logic            sub_mode;
  logic [3:0]      fact_x, fact_y, fact_z;
  logic [6:0]      size_x, size_y;
  logic [10:0]     size_z;
  int              col_sum [COLUMNS];
  int              col_cnt [COLUMNS];
  int unsigned     px, py, pz;

  block_result_t   pending_blocks[$];
  int              error_count = 0;
  int              voxels_sent = 0;
  int              blocks_seen = 0;
  int              volumes_seen = 0;
  bit              idling_on = 1'b1;
  int              hold_left = 0;
  int              stall_left = 0;

  volume_block_downsampler_unit uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .voxel_value(voxel_value),
    .empty(empty), .pop(pop), .result_q8(result_q8), .col_out(col_out),
    .row_out(row_out), .slice_out(slice_out), .volume_done(volume_done),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int unsigned eff(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void predict_voxel(logic signed [VAL_W-1:0] v);
    int unsigned   fx, fy, fz, osx, osy, osz, sx, sy, sz;
    int unsigned   lx, ly, lz, ox, oy, oz, idx;
    bit            last, done;
    longint        r;
    block_result_t b;
    fx  = eff(fact_x, 8);
    fy  = eff(fact_y, 8);
    fz  = eff(fact_z, 8);
    osx = eff(size_x, 64);
    osy = eff(size_y, 64);
    osz = eff(size_z, 1024);
    sx = osx * fx;
    sy = osy * fy;
    sz = osz * fz;
    if (px >= sx) px = 0;
    if (py >= sy) py = 0;
    if (pz >= sz) pz = 0;
    lx = px / fx; ox = px % fx;
    ly = py / fy; oy = py % fy;
    lz = pz / fz; oz = pz % fz;
    idx = (ly * osx + lx) % COLUMNS;
    if (sub_mode) begin
      if (ox == fx / 2 && oy == fy / 2 && oz == fz / 2) col_sum[idx] = v;
    end else begin
      if (ox == 0 && oy == 0 && oz == 0) begin
        col_sum[idx] = 0;
        col_cnt[idx] = 0;
      end
      if (v > 0) begin
        col_sum[idx] += v;
        col_cnt[idx] += 1;
      end
    end
    last = (ox == fx - 1) && (oy == fy - 1) && (oz == fz - 1);
    done = last && px == sx - 1 && py == sy - 1 && pz == sz - 1;
    px++;
    if (px >= sx) begin
      px = 0;
      py++;
      if (py >= sy) begin
        py = 0;
        pz++;
        if (pz >= sz) pz = 0;
      end
    end
    if (!last) return;
    if (sub_mode) r = longint'(col_sum[idx]) * 256;
    else if (col_cnt[idx] == 0) r = 0;
    else r = (longint'(col_sum[idx]) * 256) / col_cnt[idx];
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    b.value = r[RES_W-1:0];
    b.col   = lx[COL_W-1:0];
    b.row   = ly[COL_W-1:0];
    b.slice = lz[SLICE_W-1:0];
    b.done  = done;
    pending_blocks.push_back(b);
  endfunction

  task automatic report(string what, longint got, longint want);
    error_count++;
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  function automatic int gap_len();
    int r;
    if (!idling_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side: pop is driven at the rising edge, the item is checked at the
  // falling edge before the edge that accepts it.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left--;
    end else if (idling_on && $urandom_range(0, 9) < 2) begin
      pop <= 1'b0;
      stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(10, 40);
    end else begin
      pop <= 1'b1;
    end
  end

  always @(negedge clk) begin
    block_result_t b;
    if (!rst && pop && !empty) begin
      blocks_seen++;
      if (pending_blocks.size() == 0) begin
        report("unexpected result, slice", slice_out, -1);
      end else begin
        b = pending_blocks.pop_front();
        if (result_q8 !== b.value) report("result_q8", result_q8, b.value);
        if (col_out !== b.col) report("col_out", col_out, b.col);
        if (row_out !== b.row) report("row_out", row_out, b.row);
        if (slice_out !== b.slice) report("slice_out", slice_out, b.slice);
        if (volume_done !== b.done) report("volume_done", volume_done, b.done);
        if (b.done) volumes_seen++;
      end
    end
  end

  task automatic send_voxel(logic signed [VAL_W-1:0] v);
    int  g;
    bit  was_full;
    push <= 1'b1;
    voxel_value <= v;
    do begin
      @(negedge clk);
      was_full = full;
      @(posedge clk);
    end while (was_full);
    predict_voxel(v);
    voxels_sent++;
    g = gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    wait (pending_blocks.size() == 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t ri, int unsigned val);
    bit rdy;
    cfg_valid <= 1'b1;
    cfg_index <= ri;
    cfg_data  <= val[CDAT_W-1:0];
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    cfg_valid <= 1'b0;
    case (ri)
      REG_MODE:   sub_mode = val[0];
      REG_FACT_X: fact_x = val[3:0];
      REG_FACT_Y: fact_y = val[3:0];
      REG_FACT_Z: fact_z = val[3:0];
      REG_SIZE_X: size_x = val[6:0];
      REG_SIZE_Y: size_y = val[6:0];
      REG_SIZE_Z: size_z = val[10:0];
      default: ;
    endcase
    px = 0;
    py = 0;
    pz = 0;
  endtask

  task automatic set_volume(int unsigned m, int unsigned fx, int unsigned fy,
                            int unsigned fz, int unsigned sx, int unsigned sy,
                            int unsigned sz);
    wait_idle();
    write_reg(REG_MODE, m);
    write_reg(REG_FACT_X, fx);
    write_reg(REG_FACT_Y, fy);
    write_reg(REG_FACT_Z, fz);
    write_reg(REG_SIZE_X, sx);
    write_reg(REG_SIZE_Y, sy);
    write_reg(REG_SIZE_Z, sz);
  endtask

  function automatic logic signed [VAL_W-1:0] rand_voxel();
    case ($urandom_range(0, 4))
      0: return VAL_W'($urandom_range(1, 200));
      1: return VAL_W'(-$urandom_range(0, 200));
      2: return ($urandom_range(0, 1)) ? 16'sh7FFF : 16'sh8000;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  function automatic int unsigned volume_voxels();
    return eff(size_x, 64) * eff(fact_x, 8) * eff(size_y, 64) * eff(fact_y, 8) *
           eff(size_z, 1024) * eff(fact_z, 8);
  endfunction

  task automatic test_reset_defaults();
    for (int i = 0; i < 4; i++) send_voxel(rand_voxel());
  endtask

  task automatic test_single_voxel_blocks();
    logic signed [VAL_W-1:0] vals[8] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0001,
                                         16'shFFFF, 16'sh5555, 16'shAAAA, 16'sh0002};
    for (int m = 0; m < 2; m++) begin
      set_volume(m, 1, 1, 1, 8, 1, 1);
      foreach (vals[i]) send_voxel(vals[i]);
    end
  endtask

  task automatic test_empty_and_mixed_blocks();
    set_volume(0, 2, 2, 2, 1, 1, 1);
    for (int i = 0; i < 8; i++) send_voxel(VAL_W'(-i));
    for (int i = 0; i < 8; i++) send_voxel(VAL_W'((i % 3 == 0) ? i * 7 + 1 : -5));
  endtask

  task automatic test_factor_limits();
    set_volume(1, 15, 0, 1, 1, 1, 1);
    for (int i = 0; i < 8; i++) send_voxel(VAL_W'(100 + i));
    set_volume(0, 8, 8, 8, 1, 1, 1);
    for (int i = 0; i < 512; i++) send_voxel(16'sh7FFF);
  endtask

  task automatic test_size_limits();
    set_volume(0, 1, 1, 1, 127, 0, 1);
    for (int i = 0; i < 64; i++) send_voxel(rand_voxel());
    set_volume(1, 1, 1, 1, 0, 127, 1);
    for (int i = 0; i < 64; i++) send_voxel(rand_voxel());
  endtask

  task automatic test_deep_slab_with_backpressure();
    set_volume($urandom_range(0, 1), 1, 1, 1, 1, 1, 2047);
    for (int i = 0; i < 300; i++) begin
      if (i == 50) begin
        idling_on = 1'b0;
        hold_left = 400;
      end
      if (i == 150) idling_on = 1'b1;
      if (i == 200) begin
        push <= 1'b0;
        @(posedge clk);
        wait (pending_blocks.size() == 0);
        @(posedge clk);
      end
      send_voxel(rand_voxel());
    end
  endtask

  task automatic test_random_volumes();
    int unsigned n, stop;
    while (voxels_sent < 1100) begin
      do begin
        set_volume($urandom_range(0, 1), $urandom_range(0, 9), $urandom_range(0, 9),
                   $urandom_range(0, 9), $urandom_range(1, 4), $urandom_range(1, 4),
                   $urandom_range(1, 3));
        n = volume_voxels();
      end while (n > 300);
      stop = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n) : n;
      for (int i = 0; i < stop; i++) send_voxel(rand_voxel());
    end
  endtask

  initial begin
    sub_mode = 1'b0;
    fact_x = 2; fact_y = 2; fact_z = 2;
    size_x = 64; size_y = 64; size_z = 64;
    px = 0; py = 0; pz = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_single_voxel_blocks();
    test_empty_and_mixed_blocks();
    test_factor_limits();
    test_size_limits();
    test_deep_slab_with_backpressure();
    test_random_volumes();
    wait_idle();
    $display("Sent %0d voxels and checked %0d block results over %0d whole volumes.",
             voxels_sent, blocks_seen, volumes_seen);
    $display("Both modes, factors and sizes at their limits, and a stalled receiver.");
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
